// ===== sv/s2d_pkg.sv =====
package s2d_pkg;

   // default width of the converted integer
   localparam int VALUE_BITS_DEFAULT = 32;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // bits of one decimal digit and the add-3 threshold
   localparam int          DIGIT_BITS   = 4;
   localparam logic [3:0]  DABBLE_LIMIT = 4'd5;
   localparam logic [3:0]  DABBLE_ADD   = 4'd3;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic dabble;
      logic sign_out;
      logic digit_out;
      logic digit_last;
   } cmd_type;

endpackage

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Converts one two's complement integer of VALUE_BITS bits to its decimal
// text, most significant character first: a leading '-' for negative values,
// no leading zeros, a single '0' for zero, and rsp_last high on the final
// character. The item is taken when start is high while busy is low. The
// magnitude goes through a shift-and-add-3 binary-to-BCD converter that takes
// one bit per cycle, then the sign step and then the digit positions (10 at
// 32 bits) are sent in turn; busy stays high until the last digit position
// is done, so a new item is taken only once the last one is through. Each
// character is on rsp_ch/rsp_last for exactly one cycle with rsp_valid high
// and cannot be held off, so the receiver must take every character as it
// comes; cycles that skip a leading zero carry no strobe.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = s2d_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_ch,
   output logic                  rsp_last
);
   import s2d_pkg::*;

   cmd_type cmd;

   // sequencing
   s2d_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // conversion and character output
   s2d_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ch    (rsp_ch),
      .rsp_last  (rsp_last)
   );

endmodule

// ===== sv/s2d_ctrl.sv =====
module s2d_ctrl #(
   parameter int VALUE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output s2d_pkg::cmd_type cmd
);
   import s2d_pkg::*;

   localparam int DigitCount = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
   localparam int CntBits    = $clog2(VALUE_BITS);

   state_type            state_ff, state_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic                 cnt_zero;

   assign cnt_zero = (cnt_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (cnt_zero) state_in = ST_SIGN;
         end
         ST_SIGN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cnt_zero) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // step counter: bit steps, then digit positions
   always_comb begin
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) cnt_in = CntBits'(VALUE_BITS - 1);
         end
         ST_CONVERT: begin
            if (cnt_zero) cnt_in = CntBits'(DigitCount - 1);
            else          cnt_in = cnt_ff - 1'b1;
         end
         ST_SIGN: begin
            cnt_in = cnt_ff;
         end
         ST_EMIT: begin
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy           = 1'b1;
      cmd            = '0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
         end
         ST_SIGN: begin
            cmd.sign_out = 1'b1;
         end
         ST_EMIT: begin
            cmd.digit_out  = 1'b1;
            cmd.digit_last = cnt_zero;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/s2d_dp.sv =====
module s2d_dp #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  s2d_pkg::cmd_type      cmd,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_ch,
   output logic                  rsp_last
);
   import s2d_pkg::*;

   localparam int DigitCount = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
   localparam int BcdBits    = DigitCount * DIGIT_BITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BcdBits-1:0]    bcd_ff, bcd_in;
   logic [BcdBits-1:0]    bcd_adj;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_ch_ff, rsp_ch_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [3:0]            top_digit;

   assign top_digit = bcd_ff[BcdBits-1 -: DIGIT_BITS];

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DigitCount; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT)
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
               bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
         else
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
      end
   end

   // load, convert and emit
   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         neg_in     = req_value[VALUE_BITS-1];
         mag_in     = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
         bcd_in     = '0;
         started_in = 1'b0;
      end
      if (cmd.dabble) begin
         {bcd_in, mag_in} = {bcd_adj, mag_ff} << 1;
      end
      if (cmd.sign_out) begin
         rsp_valid_in = neg_ff;
         rsp_ch_in    = CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end
      if (cmd.digit_out) begin
         bcd_in = bcd_ff << DIGIT_BITS;
         // leading zeros are dropped, the units digit always goes out
         if ((top_digit != 4'd0) || started_ff || cmd.digit_last) begin
            rsp_valid_in = 1'b1;
            rsp_ch_in    = CHAR_ZERO + {4'd0, top_digit};
            rsp_last_in  = cmd.digit_last;
            started_in   = 1'b1;
         end
      end
   end

   // strobe register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // data registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      started_ff  <= started_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== sv/s2d_checker.sv =====
module s2d_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_ch,
   input logic       rsp_last
);
   import s2d_pkg::*;

   // an accepted item keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   // characters only come out of a conversion in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("character strobe without conversion");

   // the final character ends the run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("character strobe after final character");

   // only a sign or a digit is sent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ch == CHAR_MINUS) ||
                     ((rsp_ch >= CHAR_ZERO) && (rsp_ch <= CHAR_ZERO + 8'd9))))
      else $error("character is not a sign or digit");

   // a run never ends on the sign
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_ch != CHAR_MINUS))
      else $error("run ends on sign character");

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_ch    (rsp_ch),
   .rsp_last  (rsp_last)
);
